/* rtl/kpi_pkg.sv */
// kpi_pkg: shared constants, operation codes and saturating helpers
// for the keyframe pose interpolator; no dependencies
package kpi_pkg;

    localparam int MAX_KEYFRAMES = 16;
    localparam int CHANNELS      = 8;
    localparam int FRAME_W       = $clog2(MAX_KEYFRAMES);
    localparam int CH_W          = $clog2(CHANNELS);
    localparam int STORE_DEPTH   = MAX_KEYFRAMES * CHANNELS;
    localparam int ADDR_W        = FRAME_W + CH_W;
    localparam int STEPS_W       = 10;
    localparam int COUNT_W       = FRAME_W + 1;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd90;
    localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
    localparam logic signed [31:0] POSE_Y_INIT = 32'sd163840;
    localparam logic signed [31:0] POSE_Z_INIT = -32'sd229376;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAVE   = 2'd1;
    localparam logic [1:0] OP_PLAY   = 2'd2;
    localparam logic [1:0] OP_ADJUST = 2'd3;

    // saturating 32-bit add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    // clamp a 34-bit signed quotient to 32 bits
    function automatic logic signed [31:0] sat_q(input logic signed [33:0] q);
        if (q[33:31] == 3'b000 || q[33:31] == 3'b111) begin
            sat_q = q[31:0];
        end else begin
            sat_q = q[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    endfunction

endpackage

/* rtl/keyframe_pose_interpolator_core.sv */
// keyframe_pose_interpolator_core: keyframe store, playback sequencer and
// bit-serial increment divider; depends on kpi_pkg
//
// Usage: one input word (operation, channel, direction) on the s_ channel
// gives exactly one result word (the full pose and playback status) on the
// m_ channel, both valid/ready. steps_per_segment is written through
// cfg_wr_en / cfg_wr_data while the block is idle.
// Keyframes live in a 128-word synchronous memory (one word per frame and
// channel, registered read); pose and increments are registers.
// Work per item: tick, play stop, adjust and ignored save go straight
// to the result; save makes one memory write per channel; play start
// or segment change takes, for each channel in turn, two memory reads
// and a 33-step restoring divide.
// One item is in work at a time; s_ready is high only while waiting for
// an item. A finished result sits in the output register, so the next item
// is accepted while it waits; the block holds a newer result until the
// receiver takes the old one.
// Reset (aresetn low, synchronous) restores the start pose, clears the
// frame count, playback state and increments, and sets steps to 90. The
// store itself is not cleared; only written frames are ever read.
module keyframe_pose_interpolator_core
    import kpi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [9:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [2:0]         s_channel,
    input  logic               s_direction,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [31:0] m_left_knee,
    output logic signed [31:0] m_right_knee,
    output logic signed [31:0] m_right_arm,
    output logic signed [31:0] m_left_arm,
    output logic signed [31:0] m_body_turn,
    output logic               m_playing,
    output logic [4:0]         m_frames_stored,
    output logic [3:0]         m_segment
);

    typedef enum logic [2:0] {
        S_IDLE, S_SAVE, S_RDA, S_RDB, S_RDW, S_DIV, S_DIVEND, S_DONE
    } state_t;

    state_t                    state_reg;
    logic [STEPS_W-1:0]        steps_reg;
    logic signed [31:0]        pose_reg [CHANNELS];
    logic signed [31:0]        inc_reg  [CHANNELS];
    logic [COUNT_W-1:0]        fc_reg;
    logic                      play_reg;
    logic [FRAME_W-1:0]        seg_reg;
    logic [STEPS_W-1:0]        step_reg;
    logic [CH_W-1:0]           ch_reg;
    logic                      load_reg;
    logic signed [31:0]        a_reg;
    logic                      neg_reg;
    logic [32:0]               quo_reg;
    logic [STEPS_W-1:0]        rem_reg;
    logic [5:0]                bit_reg;
    logic                      m_valid_reg;
    logic signed [31:0]        out_pose_reg [CHANNELS];
    logic                      out_play_reg;
    logic [COUNT_W-1:0]        out_fc_reg;
    logic [FRAME_W-1:0]        out_seg_reg;

    // keyframe memory
    logic signed [31:0]        store_mem [STORE_DEPTH];
    logic signed [31:0]        rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      wr_en;

    logic [STEPS_W-1:0]        eff_steps;
    logic signed [32:0]        diff;
    logic [STEPS_W:0]          rem_sh;
    logic signed [33:0]        q_signed;

    // divisor: zero steps counts as one
    assign eff_steps = (steps_reg == '0) ? STEPS_W'(1) : steps_reg;

    assign rd_addr = (state_reg == S_RDA) ? {seg_reg, ch_reg}
                                          : {seg_reg + FRAME_W'(1), ch_reg};
    assign wr_addr = {fc_reg[FRAME_W-1:0], ch_reg};
    assign wr_en   = (state_reg == S_SAVE);

    assign diff     = {rd_data_reg[31], rd_data_reg} - {a_reg[31], a_reg};
    assign rem_sh   = {rem_reg, quo_reg[32]};
    assign q_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    assign s_ready = (state_reg == S_IDLE);

    // memory port: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= pose_reg[ch_reg];
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= STEPS_RESET;
        end else if (cfg_wr_en) begin
            steps_reg <= cfg_wr_data;
        end
    end

    // sequencer, pose, increments and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fc_reg      <= '0;
            play_reg    <= 1'b0;
            seg_reg     <= '0;
            step_reg    <= '0;
            ch_reg      <= '0;
            load_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                pose_reg[c] <= (c == 1) ? POSE_Y_INIT :
                               (c == 2) ? POSE_Z_INIT : 32'sd0;
                inc_reg[c]  <= '0;
            end
        end else begin
            // receiver took the word and no new one is handed over
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ch_reg <= '0;
                        case (s_operation)
                            OP_TICK: begin
                                if (play_reg) begin
                                    if (step_reg >= eff_steps) begin
                                        if ({2'b00, seg_reg} + 6'd3 > {1'b0, fc_reg}) begin
                                            play_reg  <= 1'b0;
                                            seg_reg   <= '0;
                                            state_reg <= S_DONE;
                                        end else begin
                                            seg_reg   <= seg_reg + FRAME_W'(1);
                                            step_reg  <= '0;
                                            load_reg  <= 1'b0;
                                            state_reg <= S_RDA;
                                        end
                                    end else begin
                                        for (int c = 0; c < CHANNELS; c++) begin
                                            pose_reg[c] <= sat_add(pose_reg[c], inc_reg[c]);
                                        end
                                        step_reg  <= step_reg + STEPS_W'(1);
                                        state_reg <= S_DONE;
                                    end
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_SAVE: begin
                                if (fc_reg < COUNT_W'(MAX_KEYFRAMES)) begin
                                    state_reg <= S_SAVE;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_PLAY: begin
                                if (!play_reg && fc_reg > COUNT_W'(1)) begin
                                    play_reg  <= 1'b1;
                                    seg_reg   <= '0;
                                    step_reg  <= '0;
                                    load_reg  <= 1'b1;
                                    state_reg <= S_RDA;
                                end else begin
                                    play_reg  <= 1'b0;
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_ADJUST: begin
                                pose_reg[s_channel] <= sat_add(pose_reg[s_channel],
                                    s_direction ? ONE_Q16 : -ONE_Q16);
                                state_reg <= S_DONE;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                // one channel written per cycle
                S_SAVE: begin
                    if (ch_reg == CH_W'(CHANNELS - 1)) begin
                        fc_reg    <= fc_reg + COUNT_W'(1);
                        state_reg <= S_DONE;
                    end else begin
                        ch_reg <= ch_reg + CH_W'(1);
                    end
                end
                S_RDA: begin
                    state_reg <= S_RDB;
                end
                // current frame word arrives
                S_RDB: begin
                    a_reg <= rd_data_reg;
                    if (load_reg) begin
                        pose_reg[ch_reg] <= rd_data_reg;
                    end
                    state_reg <= S_RDW;
                end
                // next frame word arrives: start the divide on the magnitude
                S_RDW: begin
                    neg_reg   <= diff[32];
                    quo_reg   <= diff[32] ? 33'(-diff) : 33'(diff);
                    rem_reg   <= '0;
                    bit_reg   <= 6'd32;
                    state_reg <= S_DIV;
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (rem_sh >= {1'b0, eff_steps}) begin
                        rem_reg <= STEPS_W'(rem_sh - {1'b0, eff_steps});
                        quo_reg <= {quo_reg[31:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[STEPS_W-1:0];
                        quo_reg <= {quo_reg[31:0], 1'b0};
                    end
                    if (bit_reg == '0) begin
                        state_reg <= S_DIVEND;
                    end else begin
                        bit_reg <= bit_reg - 6'd1;
                    end
                end
                S_DIVEND: begin
                    inc_reg[ch_reg] <= sat_q(q_signed);
                    if (ch_reg == CH_W'(CHANNELS - 1)) begin
                        state_reg <= S_DONE;
                    end else begin
                        ch_reg    <= ch_reg + CH_W'(1);
                        state_reg <= S_RDA;
                    end
                end
                // hand the word to the output register once it is free
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            out_pose_reg[c] <= pose_reg[c];
                        end
                        out_play_reg <= play_reg;
                        out_fc_reg   <= fc_reg;
                        out_seg_reg  <= seg_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pos_x         = out_pose_reg[0];
    assign m_pos_y         = out_pose_reg[1];
    assign m_pos_z         = out_pose_reg[2];
    assign m_left_knee     = out_pose_reg[3];
    assign m_right_knee    = out_pose_reg[4];
    assign m_right_arm     = out_pose_reg[5];
    assign m_left_arm      = out_pose_reg[6];
    assign m_body_turn     = out_pose_reg[7];
    assign m_playing       = out_play_reg;
    assign m_frames_stored = out_fc_reg;
    assign m_segment       = out_seg_reg;

`ifndef SYNTHESIS
    // a save never runs past the end of the store
    a_save_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SAVE) |-> (fc_reg < COUNT_W'(MAX_KEYFRAMES)))
        else $error("save with full keyframe store");

    // playback only runs with two or more frames
    a_play_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        play_reg |-> (fc_reg > COUNT_W'(1)))
        else $error("playback with fewer than two frames");

    // the played segment always has both end frames stored
    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        play_reg |-> ({2'b00, seg_reg} + 6'd2 <= {1'b0, fc_reg}))
        else $error("segment beyond stored frames");
`endif

endmodule
